// ----- rtl/core/displacement_hash_table_core_defines.svh -----
// assertion macros for the hash table core
`ifndef DISPLACEMENT_HASH_TABLE_CORE_DEFINES_SVH
`define DISPLACEMENT_HASH_TABLE_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define DHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define DHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/dht_pkg.sv -----
// shared types, constants and hash function for the hash table core
`timescale 1ns / 1ps
package dht_pkg;
    localparam int SLOTS_DEF     = 256;
    localparam int MAX_PROBE_DEF = 10;
    localparam int DIST_W        = 5;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_UPDATED  = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_SPILLED  = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
        logic [31:0] spill_key;
        logic [7:0]  slot_index;
        logic [8:0]  entry_total;
    } rsp_word_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_EVAL,
        OP_WR_UPDATE,
        OP_WR_NEW,
        OP_WR_SWAP,
        OP_WR_SPILL,
        OP_DEL_FREE,
        OP_SHIFT_READ,
        OP_SHIFT_EVAL,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   second;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
        logic empty;
        logic cand;
        logic shift_go;
        logic shift_end;
    } dp_stat_t;

    function automatic logic [31:0] mix32(input logic [31:0] k);
        logic [31:0] a;
        a = ~k + (k << 15);
        a = a ^ (a >> 12);
        a = a + (a << 2);
        a = a ^ (a >> 4);
        a = a * 32'd2057;
        a = a ^ (a >> 16);
        return a;
    endfunction
endpackage

// ----- rtl/core/displacement_hash_table_core.sv -----
// top level of the displacement hash table core
`timescale 1ns / 1ps
// channel   | ports                      | handshake
// command   | start, busy, cmd_word      | taken when start high and busy low
// result    | strobe, rsp_word           | one cycle, receiver always takes it
//
// a lookup or insert walks read, memory latency, compare and decide steps
// for each probed slot; an unused command code skips the probe and goes
// straight to the result step.
// a delete adds read, wait, shift and check steps per back-shift step.
// the table memory has a single read port, which sets the per-slot cost.
// reset clears the occupancy bits at once, so no clearing pass is needed.
// results cannot be stalled; busy falls as the strobe rises, so the next word
// can be taken at the edge that ends the strobe cycle.
module displacement_hash_table_core #(
    parameter int SLOTS     = dht_pkg::SLOTS_DEF,
    parameter int MAX_PROBE = dht_pkg::MAX_PROBE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dht_pkg::cmd_word_t cmd_word,
    output logic               strobe,
    output dht_pkg::rsp_word_t rsp_word
);
    dht_pkg::dp_cmd_t  ctl;
    dht_pkg::dp_stat_t stat;

    // sequencer: walks probe, write-back, back-shift and result steps
    dht_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (cmd_word.command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .strobe  (strobe)
    );

    // slot memories, occupancy bits, count and result formation
    dht_datapath #(
        .SLOTS     (SLOTS),
        .MAX_PROBE (MAX_PROBE)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_word),
        .ctl    (ctl),
        .stat   (stat),
        .rsp    (rsp_word)
    );
endmodule

// ----- rtl/core/dht_datapath.sv -----
// table memories, probe registers and result formation
`timescale 1ns / 1ps
module dht_datapath #(
    parameter int SLOTS     = dht_pkg::SLOTS_DEF,
    parameter int MAX_PROBE = dht_pkg::MAX_PROBE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dht_pkg::cmd_word_t cmd_in,
    input  dht_pkg::dp_cmd_t   ctl,
    output dht_pkg::dp_stat_t  stat,
    output dht_pkg::rsp_word_t rsp
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = dht_pkg::DIST_W;
    localparam logic [DW-1:0] MAXP = DW'(MAX_PROBE);

    logic [SLOTS-1:0] used_reg;
    logic [31:0]   mem_key   [SLOTS];
    logic [31:0]   mem_val   [SLOTS];
    logic [DW-1:0] mem_dist  [SLOTS];

    logic [31:0]   rd_key_reg, rd_val_reg;
    logic [DW-1:0] rd_dist_reg;
    logic          rd_used_reg;

    dht_pkg::cmd_word_t cmd_reg;
    logic [AW-1:0] home_reg, pos_reg, where_reg, hole_reg;
    logic [DW-1:0] d_reg, wdist_reg, cdist_reg, sd_reg;
    logic          cand_reg, found_reg, empty_reg, done_reg;
    logic [31:0]   dk_reg, dv_reg;
    logic [CW-1:0] count_reg;
    logic [2:0]    status_reg;
    logic          go_reg, end_reg;
    dht_pkg::rsp_word_t rsp_word;

    logic [AW-1:0] rd_addr;
    logic [31:0]   mixed;
    logic [AW-1:0] owner_home;
    logic          shift_take;

    assign mixed      = dht_pkg::mix32(cmd_in.key) & 32'h7FFF_FFFF;
    assign owner_home = pos_reg - AW'(rd_dist_reg);
    assign shift_take = rd_used_reg && (rd_dist_reg >= sd_reg);

    always_comb
    begin
        rd_addr = pos_reg;
        if (ctl.op == dht_pkg::OP_SHIFT_READ)
            rd_addr = hole_reg + AW'(sd_reg);
    end

    // memory read and write port
    always_ff @(posedge clk)
    begin
        if (ctl.op == dht_pkg::OP_READ || ctl.op == dht_pkg::OP_SHIFT_READ)
        begin
            rd_key_reg  <= mem_key[rd_addr];
            rd_val_reg  <= mem_val[rd_addr];
            rd_dist_reg <= mem_dist[rd_addr];
        end
        unique case (ctl.op) inside
            dht_pkg::OP_WR_UPDATE: mem_val[where_reg] <= cmd_reg.value;
            dht_pkg::OP_WR_NEW, dht_pkg::OP_WR_SWAP:
            begin
                mem_key[where_reg]  <= cmd_reg.key;
                mem_val[where_reg]  <= cmd_reg.value;
                mem_dist[where_reg] <= wdist_reg;
            end
            dht_pkg::OP_WR_SPILL:
            begin
                mem_key[where_reg]  <= dk_reg;
                mem_val[where_reg]  <= dv_reg;
                mem_dist[where_reg] <= wdist_reg;
            end
            dht_pkg::OP_SHIFT_EVAL:
                if (shift_take)
                begin
                    mem_key[hole_reg]  <= rd_key_reg;
                    mem_val[hole_reg]  <= rd_val_reg;
                    mem_dist[hole_reg] <= rd_dist_reg - sd_reg;
                end
            default: ;
        endcase
    end

    logic cand_hit;
    always_comb
    begin
        cand_hit = rd_used_reg && (owner_home != home_reg) && (rd_dist_reg <= cdist_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            count_reg   <= '0;
            rd_used_reg <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            empty_reg   <= 1'b0;
            cand_reg    <= 1'b0;
            go_reg      <= 1'b0;
            end_reg     <= 1'b0;
            status_reg  <= dht_pkg::ST_MISS;
        end
        else
        begin
            unique case (ctl.op)
                dht_pkg::OP_LOAD:
                begin
                    cmd_reg   <= cmd_in;
                    home_reg  <= mixed[AW-1:0];
                    pos_reg   <= mixed[AW-1:0];
                    d_reg     <= '0;
                    cdist_reg <= MAXP - 1'b1;
                    wdist_reg <= MAXP - 1'b1;
                    where_reg <= '0;
                    cand_reg  <= 1'b0;
                    found_reg <= 1'b0;
                    empty_reg <= 1'b0;
                    done_reg  <= 1'b0;
                    status_reg  <= dht_pkg::ST_MISS;
                end
                dht_pkg::OP_READ:
                begin
                    rd_used_reg <= used_reg[pos_reg];
                    done_reg    <= 1'b0;
                end
                dht_pkg::OP_EVAL:
                begin
                    if (!rd_used_reg)
                    begin
                        where_reg <= pos_reg;
                        wdist_reg <= d_reg;
                        empty_reg <= 1'b1;
                        done_reg  <= 1'b1;
                    end
                    else if (!ctl.second && owner_home == home_reg
                             && rd_key_reg == cmd_reg.key)
                    begin
                        where_reg <= pos_reg;
                        wdist_reg <= d_reg;
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        // the displaced entry's probe only looks for an empty slot
                        if (cand_hit && !ctl.second)
                        begin
                            cdist_reg <= d_reg;
                            where_reg <= pos_reg;
                            wdist_reg <= d_reg;
                            cand_reg  <= 1'b1;
                            dk_reg    <= rd_key_reg;
                            dv_reg    <= rd_val_reg;
                            sd_reg    <= rd_dist_reg;
                        end
                        pos_reg <= pos_reg + 1'b1;
                        d_reg   <= d_reg + 1'b1;
                        if (d_reg + 1'b1 >= MAXP)
                        begin
                            done_reg <= 1'b1;
                            if (count_reg >= CW'(SLOTS))
                                cand_reg <= 1'b0;
                        end
                    end
                end
                dht_pkg::OP_WR_UPDATE: status_reg <= dht_pkg::ST_UPDATED;
                dht_pkg::OP_WR_NEW:
                begin
                    used_reg[where_reg] <= 1'b1;
                    count_reg  <= count_reg + 1'b1;
                    status_reg <= dht_pkg::ST_INSERTED;
                end
                dht_pkg::OP_WR_SWAP:
                begin
                    // second probe for the displaced entry
                    home_reg  <= where_reg - AW'(sd_reg);
                    pos_reg   <= where_reg + 1'b1;
                    d_reg     <= sd_reg + 1'b1;
                    cdist_reg <= MAXP - 1'b1;
                    hole_reg  <= where_reg;
                    cand_reg  <= 1'b0;
                    empty_reg <= 1'b0;
                    done_reg  <= (sd_reg + 1'b1 >= MAXP);
                    status_reg <= dht_pkg::ST_SPILLED;
                end
                dht_pkg::OP_WR_SPILL:
                begin
                    used_reg[where_reg] <= 1'b1;
                    count_reg   <= count_reg + 1'b1;
                    status_reg  <= dht_pkg::ST_INSERTED;
                    where_reg   <= hole_reg;
                end
                dht_pkg::OP_DEL_FREE:
                begin
                    used_reg[where_reg] <= 1'b0;
                    count_reg  <= count_reg - 1'b1;
                    hole_reg   <= where_reg;
                    sd_reg     <= DW'(1);
                    status_reg <= dht_pkg::ST_DELETED;
                end
                dht_pkg::OP_SHIFT_READ:
                    rd_used_reg <= used_reg[hole_reg + AW'(sd_reg)];
                dht_pkg::OP_SHIFT_EVAL:
                begin
                    go_reg <= shift_take;
                    if (shift_take)
                    begin
                        used_reg[hole_reg] <= 1'b1;
                        used_reg[hole_reg + AW'(sd_reg)] <= 1'b0;
                        hole_reg <= hole_reg + AW'(sd_reg);
                        sd_reg   <= DW'(1);
                        end_reg  <= 1'b0;
                    end
                    else
                    begin
                        sd_reg  <= sd_reg + 1'b1;
                        end_reg <= (sd_reg + 1'b1 >= MAXP);
                    end
                end
                dht_pkg::OP_RESULT:
                begin
                    if (ctl.second)
                    begin
                        // unused command code
                        status_reg <= dht_pkg::ST_MISS;
                    end
                    else if (cmd_reg.command == dht_pkg::CMD_LOOKUP && found_reg)
                        status_reg <= dht_pkg::ST_HIT;
                    else if (cmd_reg.command == dht_pkg::CMD_INSERT && !found_reg
                             && !empty_reg && !cand_reg && status_reg == dht_pkg::ST_MISS)
                        status_reg <= dht_pkg::ST_FULL;
                end
                default: ;
            endcase
        end
    end

    // result word, formed from status after the result step
    always_comb
    begin
        rsp_word             = '0;
        rsp_word.status      = status_reg;
        rsp_word.entry_total = 9'(count_reg);
        unique case (status_reg) inside
            dht_pkg::ST_HIT:
            begin
                rsp_word.data_out   = rd_val_reg;
                rsp_word.slot_index = 8'(where_reg);
            end
            dht_pkg::ST_UPDATED, dht_pkg::ST_INSERTED:
                rsp_word.slot_index = 8'(where_reg);
            dht_pkg::ST_DELETED:
                rsp_word.slot_index = 8'(where_reg);
            dht_pkg::ST_SPILLED:
            begin
                rsp_word.data_out   = dv_reg;
                rsp_word.spill_key  = dk_reg;
                rsp_word.slot_index = 8'(hole_reg);
            end
            default: ;
        endcase
    end

    assign rsp = rsp_word;
    assign stat.done      = done_reg;
    assign stat.found     = found_reg;
    assign stat.empty     = empty_reg;
    assign stat.cand      = cand_reg;
    assign stat.shift_go  = go_reg;
    assign stat.shift_end = end_reg;
endmodule

// ----- rtl/core/dht_ctrl.sv -----
// command sequencer for the hash table core
`timescale 1ns / 1ps
`include "displacement_hash_table_core_defines.svh"
module dht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         command,
    input  dht_pkg::dp_stat_t  stat,
    output dht_pkg::dp_cmd_t   ctl,
    output logic               busy,
    output logic               strobe
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_EVAL, S_CHECK, S_ACT, S_READ2, S_WAIT2,
        S_EVAL2, S_CHECK2, S_SREAD, S_SWAIT, S_SEVAL, S_SCHECK, S_RES, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   busy_reg, busy_next;
    logic   strobe_reg, strobe_next;
    logic [1:0] cmd_reg, cmd_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = 1'b0;
        busy_next   = busy_reg;
        strobe_next = 1'b0;
        cmd_next    = cmd_reg;
        ctl.op      = dht_pkg::OP_NONE;
        ctl.second  = second_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    ctl.op    = dht_pkg::OP_LOAD;
                    cmd_next  = command;
                    busy_next = 1'b1;
                    if (command == dht_pkg::CMD_LOOKUP || command == dht_pkg::CMD_INSERT
                        || command == dht_pkg::CMD_DELETE)
                        state_next = S_READ;
                    else
                    begin
                        second_next = 1'b1;
                        state_next  = S_RES;
                    end
                end
            S_READ:  begin ctl.op = dht_pkg::OP_READ; state_next = S_WAIT; end
            S_WAIT:  state_next = S_EVAL;
            S_EVAL:  begin ctl.op = dht_pkg::OP_EVAL; ctl.second = 1'b0; state_next = S_CHECK; end
            S_CHECK: state_next = stat.done ? S_ACT : S_READ;
            S_ACT:
            begin
                state_next = S_RES;
                if (cmd_reg == dht_pkg::CMD_DELETE && stat.found)
                begin
                    ctl.op = dht_pkg::OP_DEL_FREE;
                    state_next = S_SREAD;
                end
                else if (cmd_reg == dht_pkg::CMD_INSERT)
                begin
                    if (stat.found)      ctl.op = dht_pkg::OP_WR_UPDATE;
                    else if (stat.empty) ctl.op = dht_pkg::OP_WR_NEW;
                    else if (stat.cand)
                    begin
                        ctl.op = dht_pkg::OP_WR_SWAP;
                        state_next = S_CHECK2;
                    end
                end
            end
            S_READ2:  begin ctl.op = dht_pkg::OP_READ; state_next = S_WAIT2; end
            S_WAIT2:  state_next = S_EVAL2;
            S_EVAL2:  begin ctl.op = dht_pkg::OP_EVAL; ctl.second = 1'b1; state_next = S_CHECK2; end
            S_CHECK2:
                if (!stat.done) state_next = S_READ2;
                else
                begin
                    state_next = S_RES;
                    if (stat.empty) ctl.op = dht_pkg::OP_WR_SPILL;
                end
            S_SREAD:  begin ctl.op = dht_pkg::OP_SHIFT_READ; state_next = S_SWAIT; end
            S_SWAIT:  state_next = S_SEVAL;
            S_SEVAL:  begin ctl.op = dht_pkg::OP_SHIFT_EVAL; state_next = S_SCHECK; end
            S_SCHECK: state_next = (stat.shift_go || !stat.shift_end) ? S_SREAD : S_RES;
            S_RES:
            begin
                ctl.op = dht_pkg::OP_RESULT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                strobe_next = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            cmd_reg    <= dht_pkg::CMD_LOOKUP;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            busy_reg   <= busy_next;
            strobe_reg <= strobe_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign busy   = busy_reg;
    assign strobe = strobe_reg;

    `DHT_ASSERT_IMP(a_strobe_idle, clk, rst_n, strobe_reg, state_reg == S_IDLE && !busy_reg,
        "strobe outside idle")
    `DHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy_reg, busy_reg,
        "accepted command did not raise busy")
    `DHT_ASSERT_NEXT(a_one_strobe, clk, rst_n, strobe_reg, !strobe_reg,
        "two strobes in a row")
endmodule

// ----- test/tb_displacement_hash_table_core.sv -----
// self-checking testbench for the displacement hash table core
`timescale 1ns / 1ps
module tb_displacement_hash_table_core;
    localparam int NSLOT = 256;
    localparam int NPROBE = 10;
    // a delete with a long back-shift chain is the slowest command
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int SCAN_FOUND = 0;
    localparam int SCAN_EMPTY = 1;
    localparam int SCAN_NONE = 2;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    dht_pkg::cmd_word_t cmd_word;
    logic strobe;
    dht_pkg::rsp_word_t rsp_word;

    displacement_hash_table_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd_word(cmd_word),
        .strobe(strobe),
        .rsp_word(rsp_word)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the table
    logic        tbl_used [NSLOT];
    logic [31:0] tbl_key [NSLOT];
    logic [31:0] tbl_val [NSLOT];
    int unsigned tbl_dist [NSLOT];
    int unsigned tbl_count;

    dht_pkg::rsp_word_t expected_rsp [$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int spills_seen = 0;
    int fulls_seen = 0;
    logic [31:0] live_keys [$];

    function automatic logic [31:0] hash_mix(input logic [31:0] k);
        logic [31:0] a;
        a = ~k + (k << 15);
        a = a ^ (a >> 12);
        a = a + (a << 2);
        a = a ^ (a >> 4);
        a = a * 32'd2057;
        a = a ^ (a >> 16);
        return a;
    endfunction

    function automatic int unsigned home_of(input logic [31:0] k);
        return (hash_mix(k) & 32'h7fff_ffff) % NSLOT;
    endfunction

    function automatic int unsigned back_off(input int unsigned p, input int unsigned d);
        return (p + NSLOT - (d % NSLOT)) % NSLOT;
    endfunction

    // returns found, empty or neither
    function automatic int scan_slots(input int unsigned hk, input int unsigned p0,
                                      input int unsigned d0, input bit match,
                                      input logic [31:0] k, output int unsigned where,
                                      output int unsigned wdist, output bit has_cand);
        int unsigned cdist;
        int unsigned p;
        int unsigned d;
        cdist = NPROBE - 1;
        has_cand = 0;
        where = 0;
        wdist = cdist;
        p = p0;
        d = d0;
        while (d < NPROBE)
        begin
            if (!tbl_used[p])
            begin
                where = p;
                wdist = d;
                return SCAN_EMPTY;
            end
            if (back_off(p, tbl_dist[p]) == hk)
            begin
                if (match && tbl_key[p] == k)
                begin
                    where = p;
                    wdist = d;
                    return SCAN_FOUND;
                end
            end
            else if (tbl_dist[p] <= cdist)
            begin
                cdist = d;
                where = p;
                wdist = d;
                has_cand = 1;
            end
            p = (p + 1) % NSLOT;
            d++;
        end
        if (tbl_count >= NSLOT)
            has_cand = 0;
        return SCAN_NONE;
    endfunction

    // close the gap left by a delete
    function automatic void close_gap(input int unsigned hole);
        int unsigned d;
        int unsigned c;
        d = 1;
        while (d < NPROBE)
        begin
            c = (hole + d) % NSLOT;
            if (tbl_used[c] && tbl_dist[c] >= d)
            begin
                tbl_used[hole] = 1;
                tbl_key[hole] = tbl_key[c];
                tbl_val[hole] = tbl_val[c];
                tbl_dist[hole] = tbl_dist[c] - d;
                tbl_used[c] = 0;
                hole = c;
                d = 0;
            end
            d++;
        end
    endfunction

    // apply one command to the shadow table and return its response word
    function automatic dht_pkg::rsp_word_t table_response(input dht_pkg::cmd_word_t w);
        dht_pkg::rsp_word_t r;
        int unsigned hk;
        int unsigned where;
        int unsigned wdist;
        int unsigned w2;
        int unsigned d2;
        int unsigned pos;
        int unsigned dd;
        logic [31:0] dk;
        logic [31:0] dv;
        bit cand;
        bit c2;
        int res;
        r = '0;
        r.status = dht_pkg::ST_MISS;
        hk = home_of(w.key);
        if (w.command == dht_pkg::CMD_LOOKUP || w.command == dht_pkg::CMD_INSERT
            || w.command == dht_pkg::CMD_DELETE)
        begin
            res = scan_slots(hk, hk, 0, 1, w.key, where, wdist, cand);
            if (w.command == dht_pkg::CMD_LOOKUP)
            begin
                if (res == SCAN_FOUND)
                begin
                    r.status = dht_pkg::ST_HIT;
                    r.data_out = tbl_val[where];
                    r.slot_index = where[7:0];
                end
            end
            else if (w.command == dht_pkg::CMD_DELETE)
            begin
                if (res == SCAN_FOUND)
                begin
                    tbl_used[where] = 0;
                    tbl_count--;
                    close_gap(where);
                    r.status = dht_pkg::ST_DELETED;
                    r.slot_index = where[7:0];
                end
            end
            else if (res == SCAN_FOUND)
            begin
                tbl_val[where] = w.value;
                r.status = dht_pkg::ST_UPDATED;
                r.slot_index = where[7:0];
            end
            else if (res == SCAN_EMPTY)
            begin
                tbl_used[where] = 1;
                tbl_key[where] = w.key;
                tbl_val[where] = w.value;
                tbl_dist[where] = wdist;
                tbl_count++;
                r.status = dht_pkg::ST_INSERTED;
                r.slot_index = where[7:0];
            end
            else if (!cand)
                r.status = dht_pkg::ST_FULL;
            else
            begin
                // robin hood swap, then one more probe for the evicted entry
                pos = where;
                dk = tbl_key[pos];
                dv = tbl_val[pos];
                dd = tbl_dist[pos];
                tbl_key[pos] = w.key;
                tbl_val[pos] = w.value;
                tbl_dist[pos] = wdist;
                r.slot_index = pos[7:0];
                res = scan_slots(back_off(pos, dd), (pos + 1) % NSLOT, dd + 1, 0, '0,
                                 w2, d2, c2);
                if (res == SCAN_EMPTY)
                begin
                    tbl_used[w2] = 1;
                    tbl_key[w2] = dk;
                    tbl_val[w2] = dv;
                    tbl_dist[w2] = d2;
                    tbl_count++;
                    r.status = dht_pkg::ST_INSERTED;
                end
                else
                begin
                    r.status = dht_pkg::ST_SPILLED;
                    r.data_out = dv;
                    r.spill_key = dk;
                end
            end
        end
        r.entry_total = tbl_count[8:0];
        return r;
    endfunction

    // result checker: every strobe word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, rsp_word);
                errors++;
            end
            else
            begin
                dht_pkg::rsp_word_t e;
                e = expected_rsp.pop_front();
                checked++;
                if (e.status == dht_pkg::ST_SPILLED) spills_seen++;
                if (e.status == dht_pkg::ST_FULL) fulls_seen++;
                if (e.status != rsp_word.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             rsp_word.status);
                    errors++;
                end
                if (e.data_out != rsp_word.data_out)
                begin
                    $display("%0t: data_out expected %h actual %h", $time, e.data_out,
                             rsp_word.data_out);
                    errors++;
                end
                if (e.spill_key != rsp_word.spill_key)
                begin
                    $display("%0t: spill_key expected %h actual %h", $time, e.spill_key,
                             rsp_word.spill_key);
                    errors++;
                end
                if (e.slot_index != rsp_word.slot_index)
                begin
                    $display("%0t: slot_index expected %0d actual %0d", $time, e.slot_index,
                             rsp_word.slot_index);
                    errors++;
                end
                if (e.entry_total != rsp_word.entry_total)
                begin
                    $display("%0t: entry_total expected %0d actual %0d", $time,
                             e.entry_total, rsp_word.entry_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where neither a command nor a result is taken
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("displacement_hash_table_core verification failed");
                $finish;
            end
        end
    end

    // send one command word, with a random gap first per the current idle rate
    task automatic send_word(input logic [1:0] c, input logic [31:0] k, input logic [31:0] v);
        dht_pkg::cmd_word_t w;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        w.command = c;
        w.key = k;
        w.value = v;
        start <= 1'b1;
        cmd_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        expected_rsp.push_back(table_response(w));
        sent++;
        if (c == dht_pkg::CMD_INSERT) live_keys.push_back(k);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] known_key();
        if (live_keys.size() == 0)
            return $urandom;
        return live_keys[$urandom_range(live_keys.size() - 1, 0)];
    endfunction

    // find a key whose home slot is the given one
    function automatic logic [31:0] key_homed_at(input int unsigned slot);
        logic [31:0] k;
        k = $urandom;
        while (home_of(k) != slot)
            k = $urandom;
        return k;
    endfunction

    // extremes of the fields, every command and the unused code
    task automatic test_directed_basics();
        send_word(dht_pkg::CMD_LOOKUP, 32'h0, 32'h0);
        send_word(dht_pkg::CMD_DELETE, 32'hffff_ffff, 32'h0);
        send_word(dht_pkg::CMD_INSERT, 32'h0, 32'hffff_ffff);
        send_word(dht_pkg::CMD_INSERT, 32'hffff_ffff, 32'h0);
        send_word(dht_pkg::CMD_LOOKUP, 32'h0, 32'h1234_5678);
        send_word(dht_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0);
        send_word(dht_pkg::CMD_INSERT, 32'h0, 32'ha5a5_5a5a);
        send_word(dht_pkg::CMD_LOOKUP, 32'h0, 32'h0);
        send_word(CMD_SPARE, 32'h0, 32'hffff_ffff);
        send_word(CMD_SPARE, 32'hffff_ffff, 32'h0);
        send_word(dht_pkg::CMD_DELETE, 32'h0, 32'h0);
        send_word(dht_pkg::CMD_DELETE, 32'h0, 32'h0);
        send_word(dht_pkg::CMD_LOOKUP, 32'h0, 32'h0);
        send_word(dht_pkg::CMD_DELETE, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    // cluster keys on two neighbouring home slots to hit probe limit, full and back-shift
    task automatic test_cluster();
        int unsigned h;
        logic [31:0] ks [12];
        h = $urandom_range(NSLOT - 1, 0);
        for (int i = 0; i < 12; i++)
        begin
            ks[i] = key_homed_at((h + (i % 2)) % NSLOT);
            send_word(dht_pkg::CMD_INSERT, ks[i], $urandom);
        end
        send_word(dht_pkg::CMD_DELETE, ks[0], 32'h0);
        send_word(dht_pkg::CMD_LOOKUP, ks[5], 32'h0);
        send_word(dht_pkg::CMD_DELETE, ks[1], 32'h0);
    endtask

    // random traffic, half on known keys, with the table driven near full
    task automatic test_random(input int n, input int ins_pct);
        int unsigned r;
        logic [1:0] c;
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < ins_pct) c = dht_pkg::CMD_INSERT;
            else if (r < ins_pct + (100 - ins_pct) / 2) c = dht_pkg::CMD_LOOKUP;
            else if (r < 98) c = dht_pkg::CMD_DELETE;
            else c = CMD_SPARE;
            k = ($urandom_range(1, 0) == 1) ? known_key() : $urandom;
            send_word(c, k, $urandom);
            if (i == n / 2)
            begin
                // hold off until every result is back
                wait_drained();
                repeat (8) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd_word = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_used[i] = 0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
            tbl_dist[i] = 0;
        end
        tbl_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        test_directed_basics();
        test_cluster();
        test_random(350, 70);
        send_idle_pct = 49;
        test_random(300, 60);
        send_idle_pct = 0;
        test_random(400, 45);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("commands sent %0d, results checked %0d, spills %0d, full %0d",
                 sent, checked, spills_seen, fulls_seen);
        $display("covered lookup, insert, update, delete, unused code, displacement");
        if (errors == 0 && expected_rsp.size() == 0)
            $display("displacement_hash_table_core verification clean");
        else
            $display("displacement_hash_table_core verification failed");
        $finish;
    end
endmodule

// ----- displacement_hash_table_core.f -----
+incdir+rtl/core
rtl/core/dht_pkg.sv
rtl/core/dht_datapath.sv
rtl/core/dht_ctrl.sv
rtl/core/displacement_hash_table_core.sv
test/tb_displacement_hash_table_core.sv
